@@ hdl/sst_pkg.sv @@
package sst_pkg;

	typedef enum logic [2:0] {
		CLS_IDLE,
		CLS_SPACE,
		CLS_NUMBER,
		CLS_WORD,
		CLS_STRING
	} scan_class_t;

	localparam logic [5:0] K_EOF     = 6'd0;
	localparam logic [5:0] K_EOL     = 6'd1;
	localparam logic [5:0] K_SPACE   = 6'd2;
	localparam logic [5:0] K_DECIMAL = 6'd3;
	localparam logic [5:0] K_INTEGER = 6'd4;
	localparam logic [5:0] K_BOOLEAN = 6'd5;
	localparam logic [5:0] K_IF      = 6'd6;
	localparam logic [5:0] K_ELSE    = 6'd7;
	localparam logic [5:0] K_WHILE   = 6'd8;
	localparam logic [5:0] K_FOR     = 6'd9;
	localparam logic [5:0] K_AND     = 6'd10;
	localparam logic [5:0] K_OR      = 6'd11;
	localparam logic [5:0] K_FUNC    = 6'd12;
	localparam logic [5:0] K_RETURN  = 6'd13;
	localparam logic [5:0] K_BREAK   = 6'd14;
	localparam logic [5:0] K_WORD    = 6'd15;
	localparam logic [5:0] K_STRING  = 6'd16;
	localparam logic [5:0] K_EQ      = 6'd17;
	localparam logic [5:0] K_GE      = 6'd18;
	localparam logic [5:0] K_LE      = 6'd19;
	localparam logic [5:0] K_NE      = 6'd20;
	localparam logic [5:0] K_INC     = 6'd21;
	localparam logic [5:0] K_DEC     = 6'd22;
	localparam logic [5:0] K_CARET   = 6'd23;
	localparam logic [5:0] K_PERCENT = 6'd24;
	localparam logic [5:0] K_GT      = 6'd25;
	localparam logic [5:0] K_LT      = 6'd26;
	localparam logic [5:0] K_PLUS    = 6'd27;
	localparam logic [5:0] K_MINUS   = 6'd28;
	localparam logic [5:0] K_STAR    = 6'd29;
	localparam logic [5:0] K_COMMENT = 6'd30;
	localparam logic [5:0] K_SLASH   = 6'd31;
	localparam logic [5:0] K_ASSIGN  = 6'd32;
	localparam logic [5:0] K_LBRACE  = 6'd33;
	localparam logic [5:0] K_RBRACE  = 6'd34;
	localparam logic [5:0] K_LPAREN  = 6'd35;
	localparam logic [5:0] K_RPAREN  = 6'd36;
	localparam logic [5:0] K_COMMA   = 6'd37;
	localparam logic [5:0] K_ERR     = 6'd38;

	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_EXTRA_PT   = 2'd1;
	localparam logic [1:0] ERR_TRAIL_PT   = 2'd2;
	localparam logic [1:0] ERR_UNTERM_STR = 2'd3;

	localparam logic [8:0] PEEK_END = 9'h100;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	localparam int RESULTS_MAX = 3;
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic        item_kind;
		logic [5:0]  token_kind;
		logic [7:0]  value_char;
		logic        value_kept;
		logic [1:0]  error_code;
		logic [15:0] line_number;
		logic [15:0] column_number;
		logic        last_of_run;
	} result_t;

	function automatic logic is_digit(input logic [8:0] c);
		return c >= 9'h030 && c <= 9'h039;
	endfunction

	function automatic logic is_alpha(input logic [8:0] c);
		return (c >= 9'h061 && c <= 9'h07A) || (c >= 9'h041 && c <= 9'h05A);
	endfunction

	function automatic logic is_word_char(input logic [8:0] c);
		return is_alpha(c) || is_digit(c) || c == {1'b0, CH_UNDER};
	endfunction

	function automatic logic is_space(input logic [8:0] c);
		return c == 9'h020 || (c >= 9'h009 && c <= 9'h00D && c != 9'h00A);
	endfunction

	function automatic result_t mk_item(input logic item, input logic [5:0] kind,
			input logic [7:0] ch, input logic kept, input logic [1:0] err,
			input logic [15:0] line, input logic [15:0] col);
		result_t r;
		r.item_kind     = item;
		r.token_kind    = kind;
		r.value_char    = ch;
		r.value_kept    = kept;
		r.error_code    = err;
		r.line_number   = line;
		r.column_number = col;
		r.last_of_run   = 1'b0;
		return r;
	endfunction

	// keyword kind in [6:1], kept flag in [0]; word kind when nothing matches
	function automatic logic [6:0] keyword(input logic [3:0] len, input logic [47:0] pre);
		logic [6:0] r;
		r = {K_WORD, 1'b1};
		if (len == 4'd4 && pre == 48'("true"))   r = {K_BOOLEAN, 1'b1};
		if (len == 4'd5 && pre == 48'("false"))  r = {K_BOOLEAN, 1'b1};
		if (len == 4'd2 && pre == 48'("if"))     r = {K_IF, 1'b1};
		if (len == 4'd4 && pre == 48'("else"))   r = {K_ELSE, 1'b1};
		if (len == 4'd5 && pre == 48'("while"))  r = {K_WHILE, 1'b1};
		if (len == 4'd3 && pre == 48'("FOR"))    r = {K_FOR, 1'b1};
		if (len == 4'd3 && pre == 48'("and"))    r = {K_AND, 1'b0};
		if (len == 4'd2 && pre == 48'("or"))     r = {K_OR, 1'b0};
		if (len == 4'd4 && pre == 48'("func"))   r = {K_FUNC, 1'b0};
		if (len == 4'd6 && pre == 48'("return")) r = {K_RETURN, 1'b0};
		if (len == 4'd5 && pre == 48'("break"))  r = {K_BREAK, 1'b0};
		return r;
	endfunction

	// two-byte operators; end-of-file kind means no match
	function automatic logic [5:0] pair_kind(input logic [7:0] c, input logic [8:0] p);
		logic [5:0] k;
		k = K_EOF;
		if (p == 9'h03D) begin
			unique case (c)
				8'h3D:   k = K_EQ;
				8'h3E:   k = K_GE;
				8'h3C:   k = K_LE;
				8'h21:   k = K_NE;
				default: k = K_EOF;
			endcase
		end
		if (c == 8'h26 && p == 9'h026) k = K_AND;
		if (c == 8'h7C && p == 9'h07C) k = K_OR;
		if (c == 8'h2B && p == 9'h02B) k = K_INC;
		if (c == 8'h2D && p == 9'h02D) k = K_DEC;
		if (c == 8'h2F && p == 9'h02F) k = K_COMMENT;
		return k;
	endfunction

	function automatic logic [5:0] single_kind(input logic [7:0] c);
		logic [5:0] k;
		unique case (c)
			8'h5E:   k = K_CARET;
			8'h25:   k = K_PERCENT;
			8'h3E:   k = K_GT;
			8'h3C:   k = K_LT;
			8'h2B:   k = K_PLUS;
			8'h2D:   k = K_MINUS;
			8'h2A:   k = K_STAR;
			8'h2F:   k = K_SLASH;
			8'h3D:   k = K_ASSIGN;
			8'h7B:   k = K_LBRACE;
			8'h7D:   k = K_RBRACE;
			8'h28:   k = K_LPAREN;
			8'h29:   k = K_RPAREN;
			8'h2C:   k = K_COMMA;
			default: k = K_EOF;
		endcase
		return k;
	endfunction

endpackage

@@ hdl/sst_step.sv @@
module sst_step #(
	parameter int KEYWORD_BYTES = 6,
	parameter int POSITION_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [7:0]        char_code,
	input  logic              end_of_input,
	output sst_pkg::result_t  res [sst_pkg::RESULTS_MAX],
	output logic [1:0]        res_count
);

	localparam int PW = KEYWORD_BYTES * 8;
	localparam int LW = $clog2(KEYWORD_BYTES + 2);
	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

	logic [7:0]               la_q;
	logic                     la_valid_q;
	sst_pkg::scan_class_t     cls_q;
	logic                     ps_q;
	logic [1:0]               pe_q;
	logic [PW-1:0]            pre_q;
	logic [LW-1:0]            wl_q;
	logic [POSITION_BITS-1:0] line_q;
	logic [POSITION_BITS-1:0] col_q;

	logic [7:0]               la_d;
	logic                     la_valid_d;
	sst_pkg::scan_class_t     cls_d;
	logic                     ps_d;
	logic [1:0]               pe_d;
	logic [PW-1:0]            pre_d;
	logic [LW-1:0]            wl_d;
	logic [POSITION_BITS-1:0] line_d;
	logic [POSITION_BITS-1:0] col_d;
	sst_pkg::result_t         r [sst_pkg::RESULTS_MAX];
	logic [2:0]               n;

	always_comb begin
		logic [8:0] p;
		logic [7:0] cur;
		logic       consumed;
		logic       dangling;
		logic       num_take;
		logic       word_take;
		logic       space_take;
		logic [1:0] e;
		logic [5:0] pk;
		logic [5:0] sk;
		logic [6:0] kw;

		la_d       = la_q;
		la_valid_d = la_valid_q;
		cls_d      = cls_q;
		ps_d       = ps_q;
		pe_d       = pe_q;
		pre_d      = pre_q;
		wl_d       = wl_q;
		line_d     = line_q;
		col_d      = col_q;
		for (int i = 0; i < sst_pkg::RESULTS_MAX; i++) r[i] = '0;
		n          = 3'd0;
		cur        = la_q;
		p          = end_of_input ? sst_pkg::PEEK_END : {1'b0, char_code};
		consumed   = 1'b0;
		num_take   = 1'b0;
		word_take  = 1'b0;
		space_take = 1'b0;
		e          = sst_pkg::ERR_NONE;
		pk         = sst_pkg::K_EOF;
		sk         = sst_pkg::K_EOF;
		kw         = '0;
		dangling   = end_of_input && la_valid_q && cls_q == sst_pkg::CLS_NUMBER
			&& la_q == sst_pkg::CH_POINT;

		if (dangling) begin
			e = (pe_d != sst_pkg::ERR_NONE) ? pe_d : sst_pkg::ERR_TRAIL_PT;
			if (n < 3'd3) r[n[1:0]] = sst_pkg::mk_item(1'b1, ps_d ? sst_pkg::K_DECIMAL :
				sst_pkg::K_INTEGER, 8'h00, 1'b1, e, 16'(line_d), 16'(col_d));
			n = n + 3'd1;
			cls_d = sst_pkg::CLS_IDLE;
			ps_d  = 1'b0;
			pe_d  = sst_pkg::ERR_NONE;
			if (col_d != POS_MAX) col_d = col_d + 1'b1;
			if (n < 3'd3) r[n[1:0]] = sst_pkg::mk_item(1'b1, sst_pkg::K_ERR, 8'h00, 1'b0,
				sst_pkg::ERR_NONE, 16'(line_d), 16'(col_d));
			n = n + 3'd1;
		end else if (la_valid_q) begin
			// closing of the token in progress, or its continuation
			unique case (cls_d)
				sst_pkg::CLS_NUMBER: begin
					if (sst_pkg::is_digit({1'b0, cur}) ||
							(cur == sst_pkg::CH_POINT && sst_pkg::is_digit(p))) begin
						num_take = 1'b1;
					end else begin
						e = (pe_d != sst_pkg::ERR_NONE) ? pe_d :
							(cur == sst_pkg::CH_POINT ? sst_pkg::ERR_TRAIL_PT : sst_pkg::ERR_NONE);
						if (n < 3'd3) r[n[1:0]] = sst_pkg::mk_item(1'b1, ps_d ?
							sst_pkg::K_DECIMAL : sst_pkg::K_INTEGER, 8'h00, 1'b1, e,
							16'(line_d), 16'(col_d));
						n = n + 3'd1;
						cls_d = sst_pkg::CLS_IDLE;
						ps_d  = 1'b0;
						pe_d  = sst_pkg::ERR_NONE;
					end
				end
				sst_pkg::CLS_WORD: begin
					if (sst_pkg::is_word_char({1'b0, cur})) begin
						word_take = 1'b1;
					end else begin
						kw = sst_pkg::keyword(4'(wl_d), 48'(pre_d));
						if (n < 3'd3) r[n[1:0]] = sst_pkg::mk_item(1'b1, kw[6:1], 8'h00, kw[0],
							sst_pkg::ERR_NONE, 16'(line_d), 16'(col_d));
						n = n + 3'd1;
						cls_d = sst_pkg::CLS_IDLE;
						pre_d = '0;
						wl_d  = '0;
					end
				end
				sst_pkg::CLS_SPACE: begin
					if (sst_pkg::is_space({1'b0, cur})) begin
						space_take = 1'b1;
					end else begin
						if (n < 3'd3) r[n[1:0]] = sst_pkg::mk_item(1'b1, sst_pkg::K_SPACE, 8'h00,
							1'b0, sst_pkg::ERR_NONE, 16'(line_d), 16'(col_d));
						n = n + 3'd1;
						cls_d = sst_pkg::CLS_IDLE;
					end
				end
				sst_pkg::CLS_STRING: begin
					if (cur == sst_pkg::CH_QUOTE) begin
						if (col_d != POS_MAX) col_d = col_d + 1'b1;
						if (n < 3'd3) r[n[1:0]] = sst_pkg::mk_item(1'b1, sst_pkg::K_STRING, 8'h00,
							1'b1, sst_pkg::ERR_NONE, 16'(line_d), 16'(col_d));
						n = n + 3'd1;
						cls_d = sst_pkg::CLS_IDLE;
					end else begin
						if (n < 3'd3) r[n[1:0]] = sst_pkg::mk_item(1'b0, sst_pkg::K_STRING, cur,
							1'b0, sst_pkg::ERR_NONE, 16'(line_d), 16'(col_d));
						n = n + 3'd1;
						if (col_d != POS_MAX) col_d = col_d + 1'b1;
					end
				end
				default: cls_d = sst_pkg::CLS_IDLE;
			endcase

			// start of a new token
			if (cls_d == sst_pkg::CLS_IDLE && cls_q != sst_pkg::CLS_STRING &&
					!num_take && !word_take && !space_take) begin
				pk = sst_pkg::pair_kind(cur, p);
				sk = sst_pkg::single_kind(cur);
				if (cur == sst_pkg::CH_NL) begin
					if (n < 3'd3) r[n[1:0]] = sst_pkg::mk_item(1'b1, sst_pkg::K_EOL, 8'h00, 1'b0,
						sst_pkg::ERR_NONE, 16'(line_d), 16'd0);
					n = n + 3'd1;
					if (line_d != POS_MAX) line_d = line_d + 1'b1;
					col_d = '0;
				end else if (cur == sst_pkg::CH_SEMI) begin
					if (n < 3'd3) r[n[1:0]] = sst_pkg::mk_item(1'b1, sst_pkg::K_EOL, 8'h00, 1'b0,
						sst_pkg::ERR_NONE, 16'(line_d), 16'd0);
					n = n + 3'd1;
					if (col_d != POS_MAX) col_d = col_d + 1'b1;
				end else if (sst_pkg::is_space({1'b0, cur})) begin
					space_take = 1'b1;
				end else if (sst_pkg::is_digit({1'b0, cur}) ||
						(cur == sst_pkg::CH_POINT && sst_pkg::is_digit(p))) begin
					ps_d = 1'b0;
					pe_d = sst_pkg::ERR_NONE;
					num_take = 1'b1;
				end else if (sst_pkg::is_alpha({1'b0, cur}) || cur == sst_pkg::CH_UNDER) begin
					pre_d = '0;
					wl_d  = '0;
					word_take = 1'b1;
				end else if (cur == sst_pkg::CH_QUOTE) begin
					if (col_d != POS_MAX) col_d = col_d + 1'b1;
					cls_d = sst_pkg::CLS_STRING;
				end else if (pk != sst_pkg::K_EOF) begin
					if (col_d != POS_MAX) col_d = col_d + 1'b1;
					if (col_d != POS_MAX) col_d = col_d + 1'b1;
					if (n < 3'd3) r[n[1:0]] = sst_pkg::mk_item(1'b1, pk, 8'h00, 1'b0,
						sst_pkg::ERR_NONE, 16'(line_d), 16'(col_d));
					n = n + 3'd1;
					consumed = 1'b1;
				end else if (sk != sst_pkg::K_EOF) begin
					if (col_d != POS_MAX) col_d = col_d + 1'b1;
					if (n < 3'd3) r[n[1:0]] = sst_pkg::mk_item(1'b1, sk, 8'h00, 1'b0,
						sst_pkg::ERR_NONE, 16'(line_d), 16'(col_d));
					n = n + 3'd1;
				end else begin
					if (n < 3'd3) r[n[1:0]] = sst_pkg::mk_item(1'b0, sst_pkg::K_ERR, cur, 1'b0,
						sst_pkg::ERR_NONE, 16'(line_d), 16'(col_d));
					n = n + 3'd1;
					if (col_d != POS_MAX) col_d = col_d + 1'b1;
					if (n < 3'd3) r[n[1:0]] = sst_pkg::mk_item(1'b1, sst_pkg::K_ERR, 8'h00, 1'b1,
						sst_pkg::ERR_NONE, 16'(line_d), 16'(col_d));
					n = n + 3'd1;
				end
			end

			if (num_take) begin
				if (cur == sst_pkg::CH_POINT) begin
					if (ps_d && pe_d == sst_pkg::ERR_NONE) pe_d = sst_pkg::ERR_EXTRA_PT;
					ps_d = 1'b1;
				end
				if (n < 3'd3) r[n[1:0]] = sst_pkg::mk_item(1'b0, sst_pkg::K_DECIMAL, cur, 1'b0,
					sst_pkg::ERR_NONE, 16'(line_d), 16'(col_d));
				n = n + 3'd1;
				if (col_d != POS_MAX) col_d = col_d + 1'b1;
				cls_d = sst_pkg::CLS_NUMBER;
				if (!(sst_pkg::is_digit(p) || p == {1'b0, sst_pkg::CH_POINT})) begin
					if (n < 3'd3) r[n[1:0]] = sst_pkg::mk_item(1'b1, ps_d ? sst_pkg::K_DECIMAL :
						sst_pkg::K_INTEGER, 8'h00, 1'b1, pe_d, 16'(line_d), 16'(col_d));
					n = n + 3'd1;
					cls_d = sst_pkg::CLS_IDLE;
					ps_d  = 1'b0;
					pe_d  = sst_pkg::ERR_NONE;
				end
			end

			if (word_take) begin
				if (n < 3'd3) r[n[1:0]] = sst_pkg::mk_item(1'b0, sst_pkg::K_WORD, cur, 1'b0,
					sst_pkg::ERR_NONE, 16'(line_d), 16'(col_d));
				n = n + 3'd1;
				if (wl_d < LW'(KEYWORD_BYTES)) begin
					pre_d = {pre_d[PW-9:0], cur};
					wl_d  = wl_d + 1'b1;
				end else begin
					wl_d = LW'(KEYWORD_BYTES + 1);
				end
				if (col_d != POS_MAX) col_d = col_d + 1'b1;
				cls_d = sst_pkg::CLS_WORD;
				if (!sst_pkg::is_word_char(p)) begin
					kw = sst_pkg::keyword(4'(wl_d), 48'(pre_d));
					if (n < 3'd3) r[n[1:0]] = sst_pkg::mk_item(1'b1, kw[6:1], 8'h00, kw[0],
						sst_pkg::ERR_NONE, 16'(line_d), 16'(col_d));
					n = n + 3'd1;
					cls_d = sst_pkg::CLS_IDLE;
					pre_d = '0;
					wl_d  = '0;
				end
			end

			if (space_take) begin
				if (col_d != POS_MAX) col_d = col_d + 1'b1;
				cls_d = sst_pkg::CLS_SPACE;
				if (!sst_pkg::is_space(p)) begin
					if (n < 3'd3) r[n[1:0]] = sst_pkg::mk_item(1'b1, sst_pkg::K_SPACE, 8'h00,
						1'b0, sst_pkg::ERR_NONE, 16'(line_d), 16'(col_d));
					n = n + 3'd1;
					cls_d = sst_pkg::CLS_IDLE;
				end
			end
		end

		if (end_of_input) begin
			unique case (cls_d)
				sst_pkg::CLS_STRING: begin
					if (col_d != POS_MAX) col_d = col_d + 1'b1;
					if (n < 3'd3) r[n[1:0]] = sst_pkg::mk_item(1'b1, sst_pkg::K_STRING, 8'h00,
						1'b1, sst_pkg::ERR_UNTERM_STR, 16'(line_d), 16'(col_d));
					n = n + 3'd1;
				end
				sst_pkg::CLS_NUMBER: begin
					if (n < 3'd3) r[n[1:0]] = sst_pkg::mk_item(1'b1, ps_d ? sst_pkg::K_DECIMAL :
						sst_pkg::K_INTEGER, 8'h00, 1'b1, pe_d, 16'(line_d), 16'(col_d));
					n = n + 3'd1;
				end
				sst_pkg::CLS_WORD: begin
					kw = sst_pkg::keyword(4'(wl_d), 48'(pre_d));
					if (n < 3'd3) r[n[1:0]] = sst_pkg::mk_item(1'b1, kw[6:1], 8'h00, kw[0],
						sst_pkg::ERR_NONE, 16'(line_d), 16'(col_d));
					n = n + 3'd1;
				end
				sst_pkg::CLS_SPACE: begin
					if (n < 3'd3) r[n[1:0]] = sst_pkg::mk_item(1'b1, sst_pkg::K_SPACE, 8'h00,
						1'b0, sst_pkg::ERR_NONE, 16'(line_d), 16'(col_d));
					n = n + 3'd1;
				end
				default: ;
			endcase
			if (n < 3'd3) r[n[1:0]] = sst_pkg::mk_item(1'b1, sst_pkg::K_EOF, 8'h00, 1'b0,
				sst_pkg::ERR_NONE, 16'(line_d), 16'(col_d));
			n = n + 3'd1;
			la_d       = '0;
			la_valid_d = 1'b0;
			cls_d      = sst_pkg::CLS_IDLE;
			ps_d       = 1'b0;
			pe_d       = sst_pkg::ERR_NONE;
			pre_d      = '0;
			wl_d       = '0;
			line_d     = POSITION_BITS'(1);
			col_d      = '0;
		end else if (!la_valid_q) begin
			la_d       = char_code;
			la_valid_d = 1'b1;
		end else if (consumed) begin
			la_valid_d = 1'b0;
		end else begin
			la_d = char_code;
		end

		if (n > 3'd3) n = 3'd3;
		if (n != 3'd0) r[2'(n - 3'd1)].last_of_run = 1'b1;
	end

	assign res       = r;
	assign res_count = n[1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			la_q       <= '0;
			la_valid_q <= 1'b0;
			cls_q      <= sst_pkg::CLS_IDLE;
			ps_q       <= 1'b0;
			pe_q       <= sst_pkg::ERR_NONE;
			pre_q      <= '0;
			wl_q       <= '0;
			line_q     <= POSITION_BITS'(1);
			col_q      <= '0;
		end else if (go) begin
			la_q       <= la_d;
			la_valid_q <= la_valid_d;
			cls_q      <= cls_d;
			ps_q       <= ps_d;
			pe_q       <= pe_d;
			pre_q      <= pre_d;
			wl_q       <= wl_d;
			line_q     <= line_d;
			col_q      <= col_d;
		end
	end

endmodule

@@ hdl/sst_queue.sv @@
module sst_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sst_pkg::result_t  wr_data [sst_pkg::RESULTS_MAX],
	input  logic [1:0]        wr_count,
	output logic              room,
	output logic              out_valid,
	input  logic              out_ready,
	output sst_pkg::result_t  out_data
);

	sst_pkg::result_t ent_q [sst_pkg::QUEUE_DEPTH];
	logic [1:0]       wr_q;
	logic [1:0]       rd_q;
	logic [2:0]       cnt_q;
	logic             pop;
	logic [1:0]       n_in;

	assign pop       = out_valid && out_ready;
	assign out_valid = cnt_q != 3'd0;
	assign out_data  = ent_q[rd_q];
	// room for a full batch of results
	assign room      = (cnt_q - {2'b00, pop}) <= 3'd1;
	assign n_in      = push ? wr_count : 2'd0;

	always_ff @(posedge clk) begin
		for (int i = 0; i < sst_pkg::RESULTS_MAX; i++) begin
			if (2'(i) < n_in) ent_q[2'(wr_q + 2'(i))] <= wr_data[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_in;
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, n_in} - {2'b00, pop};
		end
	end

endmodule

@@ hdl/script_source_tokenizer.sv @@
// Source bytes go in on s_tdata, one per transaction; a transaction with s_tlast set ends the
// source, closes any pending token and yields the end-of-file token, after which the next
// byte starts a fresh source at line 1. Every byte transaction causes zero to three result
// transactions, which queue in a four-entry output buffer; the input is taken every cycle as
// long as that buffer can hold a full batch, so the sustained rate is one byte per cycle when
// the output side keeps up, and the output port drains one result per cycle with m_tready
// high. A token's value bytes come out first (m_tuser low), then its end item (m_tuser high).
module script_source_tokenizer #(
	parameter int KEYWORD_BYTES = 6,
	parameter int POSITION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_code
	input  logic        s_tlast,   // end_of_input
	output logic        m_tvalid,
	input  logic        m_tready,
	// token_kind, value_char, value_kept, error_code, line_number, column_number, zero pad
	output logic [55:0] m_tdata,
	output logic        m_tuser,   // item_kind
	output logic        m_tlast    // last_of_run
);

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             eoi_s1;
	logic             room;
	logic             go;
	sst_pkg::result_t res [sst_pkg::RESULTS_MAX];
	logic [1:0]       res_count;
	sst_pkg::result_t head;

	assign go       = valid_s1 && room;
	assign s_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			eoi_s1  <= s_tlast;
		end
	end

	sst_step #(
		.KEYWORD_BYTES(KEYWORD_BYTES),
		.POSITION_BITS(POSITION_BITS)
	) u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (go),
		.char_code    (char_s1),
		.end_of_input (eoi_s1),
		.res          (res),
		.res_count    (res_count)
	);

	sst_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (go),
		.wr_data   (res),
		.wr_count  (res_count),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (head)
	);

	assign m_tdata = {7'd0, head.column_number, head.line_number, head.error_code,
		head.value_kept, head.value_char, head.token_kind};
	assign m_tuser = head.item_kind;
	assign m_tlast = head.last_of_run;

endmodule

@@ hdl/sst_checker.sv @@
module sst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled transaction changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> !m_tdata[14] && m_tdata[16:15] == sst_pkg::ERR_NONE)
		else $error("value byte with flags");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && m_tdata[5:0] == sst_pkg::K_EOF |-> m_tlast)
		else $error("end of file not last of run");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && m_tdata[5:0] == sst_pkg::K_EOL |-> m_tdata[48:33] == 16'd0)
		else $error("end of line with nonzero column");

endmodule

bind script_source_tokenizer sst_checker u_sst_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

@@ dv/tb_script_source_tokenizer.sv @@
`timescale 1ns / 1ps

module tb_script_source_tokenizer;
	import sst_pkg::*;

	typedef struct packed {
		logic        item;
		logic [5:0]  kind;
		logic [7:0]  ch;
		logic        kept;
		logic [1:0]  err;
		logic [15:0] line;
		logic [15:0] col;
		logic        last;
	} tok_res_t;

	typedef struct {
		logic       eoi;
		logic [7:0] ch;
		logic       typed;
		logic [5:0] kind;
		logic [1:0] err;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	script_source_tokenizer i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// tokenizer state mirror
	logic [7:0]  la_byte;
	logic        la_ok;
	scan_class_t cls;
	logic        pt_seen;
	logic [1:0]  pend_err;
	logic [47:0] wpre;
	int          wlen;
	logic [15:0] line_cnt;
	logic [15:0] col_cnt;

	tok_res_t tokens_due[$];
	tok_res_t batch[$];
	int       errors = 0;
	bit       calm = 1'b0;
	bit       hold_req = 1'b0;
	int       stall_cnt = 0;
	int       sent = 0;

	function automatic bit c_dig(int c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit c_alpha(int c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit c_wordc(int c);
		return c_alpha(c) || c_dig(c) || c == "_";
	endfunction

	function automatic bit c_space(int c);
		return c == " " || (c >= 9 && c <= 13 && c != 10);
	endfunction

	function automatic logic [5:0] op_pair(int c, int p);
		if (c == "&" && p == "&") return K_AND;
		if (c == "|" && p == "|") return K_OR;
		if (c == "=" && p == "=") return K_EQ;
		if (c == ">" && p == "=") return K_GE;
		if (c == "<" && p == "=") return K_LE;
		if (c == "!" && p == "=") return K_NE;
		if (c == "+" && p == "+") return K_INC;
		if (c == "-" && p == "-") return K_DEC;
		if (c == "/" && p == "/") return K_COMMENT;
		return K_EOF;
	endfunction

	function automatic logic [5:0] op_single(int c);
		case (c)
			"^": return K_CARET;
			"%": return K_PERCENT;
			">": return K_GT;
			"<": return K_LT;
			"+": return K_PLUS;
			"-": return K_MINUS;
			"*": return K_STAR;
			"/": return K_SLASH;
			"=": return K_ASSIGN;
			"{": return K_LBRACE;
			"}": return K_RBRACE;
			"(": return K_LPAREN;
			")": return K_RPAREN;
			",": return K_COMMA;
			default: return K_EOF;
		endcase
	endfunction

	task automatic clear_state();
		la_byte = 8'd0;
		la_ok = 1'b0;
		cls = CLS_IDLE;
		pt_seen = 1'b0;
		pend_err = ERR_NONE;
		wpre = '0;
		wlen = 0;
		line_cnt = 16'd1;
		col_cnt = 16'd0;
	endtask

	task automatic put(logic item, logic [5:0] kind, int ch, logic kept, logic [1:0] err,
			logic [15:0] line, logic [15:0] col);
		tok_res_t r;
		r = '{item, kind, ch[7:0], kept, err, line, col, 1'b0};
		if (batch.size() < RESULTS_MAX) batch.insert(batch.size(), r);
	endtask

	task automatic put_end(logic [5:0] kind, logic kept, logic [1:0] err);
		put(1'b1, kind, 0, kept, err, line_cnt, col_cnt);
	endtask

	task automatic adv();
		if (col_cnt != 16'hFFFF) col_cnt++;
	endtask

	task automatic close_num(logic [1:0] e);
		put_end(pt_seen ? K_DECIMAL : K_INTEGER, 1'b1, pend_err != ERR_NONE ? pend_err : e);
		cls = CLS_IDLE;
		pt_seen = 1'b0;
		pend_err = ERR_NONE;
	endtask

	task automatic close_word();
		logic [5:0] k;
		logic kept;
		k = K_WORD;
		kept = 1'b1;
		if (wlen == 4 && wpre == 48'("true"))   begin k = K_BOOLEAN; kept = 1'b1; end
		if (wlen == 5 && wpre == 48'("false"))  begin k = K_BOOLEAN; kept = 1'b1; end
		if (wlen == 2 && wpre == 48'("if"))     begin k = K_IF;      kept = 1'b1; end
		if (wlen == 4 && wpre == 48'("else"))   begin k = K_ELSE;    kept = 1'b1; end
		if (wlen == 5 && wpre == 48'("while"))  begin k = K_WHILE;   kept = 1'b1; end
		if (wlen == 3 && wpre == 48'("FOR"))    begin k = K_FOR;     kept = 1'b1; end
		if (wlen == 3 && wpre == 48'("and"))    begin k = K_AND;     kept = 1'b0; end
		if (wlen == 2 && wpre == 48'("or"))     begin k = K_OR;      kept = 1'b0; end
		if (wlen == 4 && wpre == 48'("func"))   begin k = K_FUNC;    kept = 1'b0; end
		if (wlen == 6 && wpre == 48'("return")) begin k = K_RETURN;  kept = 1'b0; end
		if (wlen == 5 && wpre == 48'("break"))  begin k = K_BREAK;   kept = 1'b0; end
		put_end(k, kept, ERR_NONE);
		cls = CLS_IDLE;
		wpre = '0;
		wlen = 0;
	endtask

	task automatic num_take(int cur, int p);
		if (cur == CH_POINT) begin
			if (pt_seen && pend_err == ERR_NONE) pend_err = ERR_EXTRA_PT;
			pt_seen = 1'b1;
		end
		put(1'b0, K_DECIMAL, cur, 1'b0, ERR_NONE, line_cnt, col_cnt);
		adv();
		cls = CLS_NUMBER;
		if (!(c_dig(p) || p == CH_POINT)) close_num(ERR_NONE);
	endtask

	task automatic word_take(int cur, int p);
		put(1'b0, K_WORD, cur, 1'b0, ERR_NONE, line_cnt, col_cnt);
		if (wlen < 6) begin
			wpre = {wpre[39:0], cur[7:0]};
			wlen++;
		end else begin
			wlen = 7;
		end
		adv();
		cls = CLS_WORD;
		if (!c_wordc(p)) close_word();
	endtask

	task automatic space_take(int p);
		adv();
		cls = CLS_SPACE;
		if (!c_space(p)) begin
			put_end(K_SPACE, 1'b0, ERR_NONE);
			cls = CLS_IDLE;
		end
	endtask

	task automatic idle_take(int cur, int p, output bit both);
		logic [5:0] k;
		both = 1'b0;
		k = op_pair(cur, p);
		if (cur == CH_NL) begin
			put(1'b1, K_EOL, 0, 1'b0, ERR_NONE, line_cnt, 16'd0);
			if (line_cnt != 16'hFFFF) line_cnt++;
			col_cnt = 16'd0;
		end else if (cur == CH_SEMI) begin
			put(1'b1, K_EOL, 0, 1'b0, ERR_NONE, line_cnt, 16'd0);
			adv();
		end else if (c_space(cur)) begin
			space_take(p);
		end else if (c_dig(cur) || (cur == CH_POINT && c_dig(p))) begin
			pt_seen = 1'b0;
			pend_err = ERR_NONE;
			num_take(cur, p);
		end else if (c_alpha(cur) || cur == CH_UNDER) begin
			wpre = '0;
			wlen = 0;
			word_take(cur, p);
		end else if (cur == CH_QUOTE) begin
			adv();
			cls = CLS_STRING;
		end else if (k != K_EOF) begin
			adv();
			adv();
			put_end(k, 1'b0, ERR_NONE);
			both = 1'b1;
		end else if (op_single(cur) != K_EOF) begin
			adv();
			put_end(op_single(cur), 1'b0, ERR_NONE);
		end else begin
			put(1'b0, K_ERR, cur, 1'b0, ERR_NONE, line_cnt, col_cnt);
			adv();
			put_end(K_ERR, 1'b1, ERR_NONE);
		end
	endtask

	task automatic take_cur(int cur, int p, output bit both);
		both = 1'b0;
		case (cls)
			CLS_NUMBER: begin
				if (c_dig(cur) || (cur == CH_POINT && c_dig(p))) begin
					num_take(cur, p);
					return;
				end
				close_num(cur == CH_POINT ? ERR_TRAIL_PT : ERR_NONE);
			end
			CLS_WORD: begin
				if (c_wordc(cur)) begin
					word_take(cur, p);
					return;
				end
				close_word();
			end
			CLS_SPACE: begin
				if (c_space(cur)) begin
					space_take(p);
					return;
				end
				put_end(K_SPACE, 1'b0, ERR_NONE);
				cls = CLS_IDLE;
			end
			CLS_STRING: begin
				if (cur == CH_QUOTE) begin
					adv();
					put_end(K_STRING, 1'b1, ERR_NONE);
					cls = CLS_IDLE;
				end else begin
					put(1'b0, K_STRING, cur, 1'b0, ERR_NONE, line_cnt, col_cnt);
					adv();
				end
				return;
			end
			default: cls = CLS_IDLE;
		endcase
		idle_take(cur, p, both);
	endtask

	task automatic tokenize_step(logic eoi, logic [7:0] ch);
		bit both;
		batch.delete();
		if (eoi) begin
			if (la_ok) begin
				if (cls == CLS_NUMBER && la_byte == CH_POINT) begin
					close_num(ERR_TRAIL_PT);
					adv();
					put_end(K_ERR, 1'b0, ERR_NONE);
				end else begin
					take_cur(la_byte, PEEK_END, both);
				end
			end
			case (cls)
				CLS_STRING: begin
					adv();
					put_end(K_STRING, 1'b1, ERR_UNTERM_STR);
				end
				CLS_NUMBER: close_num(ERR_NONE);
				CLS_WORD:   close_word();
				CLS_SPACE:  put_end(K_SPACE, 1'b0, ERR_NONE);
				default: ;
			endcase
			put_end(K_EOF, 1'b0, ERR_NONE);
			clear_state();
		end else if (!la_ok) begin
			la_byte = ch;
			la_ok = 1'b1;
		end else begin
			take_cur(la_byte, ch, both);
			if (both) la_ok = 1'b0;
			else la_byte = ch;
		end
		if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i]) tokens_due.insert(tokens_due.size(), batch[i]);
	endtask

	task automatic send(logic eoi, logic [7:0] ch);
		while (!calm && $urandom_range(99) < 34) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ch;
		s_tlast <= eoi;
		forever begin
			@(negedge clk);
			if (s_tready) begin
				tokenize_step(eoi, ch);
				sent++;
				@(posedge clk);
				break;
			end
			@(posedge clk);
		end
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send(1'b0, s[i]);
	endtask

	task automatic random_token();
		string words[13] = '{"true", "false", "if", "else", "while", "FOR", "and", "or",
			"func", "return", "break", "returns", "fo"};
		string idc = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
		string ops = "==>=<=!=++--//&&||^%><+-*/={}(),";
		string spc = " \t\013\014\015";
		int r;
		int n;
		r = $urandom_range(99);
		if (r < 25) begin
			if ($urandom_range(1)) begin
				send_text(words[$urandom_range(12)]);
			end else begin
				n = $urandom_range(9, 1);
				send(1'b0, idc[$urandom_range(52)]);
				repeat (n - 1) send(1'b0, idc[$urandom_range(62)]);
			end
		end else if (r < 40) begin
			repeat ($urandom_range(4, 1)) send(1'b0, 8'("0") + 8'($urandom_range(9)));
			n = $urandom_range(9);
			if (n < 5) begin
				send(1'b0, CH_POINT);
				repeat ($urandom_range(2, 1)) send(1'b0, 8'("0") + 8'($urandom_range(9)));
			end
			if (n == 5 || n == 6) send(1'b0, CH_POINT);
			if (n == 6) send(1'b0, 8'("0") + 8'($urandom_range(9)));
		end else if (r < 50) begin
			send(1'b0, CH_QUOTE);
			repeat ($urandom_range(5)) send(1'b0, 8'($urandom_range(126, 32)));
			if ($urandom_range(19) == 0) send(1'b1, 8'($urandom));
			else send(1'b0, CH_QUOTE);
		end else if (r < 65) begin
			send(1'b0, ops[$urandom_range(ops.len() - 1)]);
		end else if (r < 75) begin
			repeat ($urandom_range(3, 1)) send(1'b0, spc[$urandom_range(4)]);
		end else if (r < 83) begin
			send(1'b0, $urandom_range(1) ? CH_NL : CH_SEMI);
		end else if (r < 88) begin
			send(1'b0, 8'($urandom));
		end else if (r < 90) begin
			send(1'b1, 8'($urandom));
		end else begin
			send(1'b0, $urandom_range(1) ? CH_POINT : CH_QUOTE);
		end
	endtask

	// receiver: random back-pressure, with one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (200) @(posedge clk);
			end
			m_tready <= calm || $urandom_range(99) >= 34;
		end
	end

	always @(negedge clk) begin
		tok_res_t g;
		tok_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			g = '{m_tuser, m_tdata[5:0], m_tdata[13:6], m_tdata[14], m_tdata[16:15],
				m_tdata[32:17], m_tdata[48:33], m_tlast};
			if (tokens_due.size() == 0) begin
				$display("%0t: unexpected result, got %p", $time, g);
				errors++;
			end else begin
				e = tokens_due.pop_front();
				if (g !== e) begin
					$display("%0t: mismatch, expected %p, got %p", $time, e, g);
					errors++;
				end
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cnt = 0;
		else stall_cnt++;
		if (stall_cnt >= 2000) begin
			$display("tb_script_source_tokenizer NOT OK");
			$finish;
		end
	end

	initial begin
		stim_row_t rows[$];
		bit hit;
		rows = '{
			'{1'b1, 8'h00, 1'b1, K_EOF, ERR_NONE},
			'{1'b0, "1", 1'b0, K_EOF, ERR_NONE},
			'{1'b0, ".", 1'b0, K_EOF, ERR_NONE},
			'{1'b0, "2", 1'b0, K_EOF, ERR_NONE},
			'{1'b0, ".", 1'b0, K_EOF, ERR_NONE},
			'{1'b0, "3", 1'b0, K_EOF, ERR_NONE},
			'{1'b1, 8'h00, 1'b1, K_DECIMAL, ERR_EXTRA_PT},
			'{1'b0, "7", 1'b0, K_EOF, ERR_NONE},
			'{1'b0, ".", 1'b0, K_EOF, ERR_NONE},
			'{1'b1, 8'hFF, 1'b1, K_INTEGER, ERR_TRAIL_PT},
			'{1'b0, 8'h22, 1'b0, K_EOF, ERR_NONE},
			'{1'b0, "a", 1'b0, K_EOF, ERR_NONE},
			'{1'b1, 8'h00, 1'b1, K_STRING, ERR_UNTERM_STR},
			'{1'b0, 8'hFF, 1'b0, K_EOF, ERR_NONE},
			'{1'b0, 8'h00, 1'b1, K_ERR, ERR_NONE},
			'{1'b0, "i", 1'b1, K_ERR, ERR_NONE},
			'{1'b0, "f", 1'b0, K_EOF, ERR_NONE},
			'{1'b0, 8'h0A, 1'b1, K_IF, ERR_NONE},
			'{1'b0, "=", 1'b1, K_EOL, ERR_NONE},
			'{1'b0, "=", 1'b1, K_EQ, ERR_NONE},
			'{1'b0, ";", 1'b0, K_EOF, ERR_NONE},
			'{1'b0, "\t", 1'b0, K_EOF, ERR_NONE},
			'{1'b1, 8'h00, 1'b1, K_EOF, ERR_NONE}
		};
		clear_state();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			send(rows[i].eoi, rows[i].ch);
			if (rows[i].typed) begin
				hit = 1'b0;
				foreach (batch[j])
					if (batch[j].item && batch[j].kind == rows[i].kind &&
							batch[j].err == rows[i].err) hit = 1'b1;
				if (!hit) begin
					$display("%0t: mismatch, expected kind %0d error %0d, got %p", $time,
						rows[i].kind, rows[i].err, batch);
					errors++;
				end
			end
		end
		calm = 1'b1;
		while (sent < 100) random_token();
		calm = 1'b0;
		while (sent < 180) random_token();
		hold_req = 1'b1;
		while (sent < 368) random_token();
		send(1'b1, 8'h00);
		s_tvalid <= 1'b0;
		while (tokens_due.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && tokens_due.size() == 0)
			$display("tb_script_source_tokenizer OK");
		else
			$display("tb_script_source_tokenizer NOT OK");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/sst_pkg.sv
hdl/sst_step.sv
hdl/sst_queue.sv
hdl/script_source_tokenizer.sv
hdl/sst_checker.sv
dv/tb_script_source_tokenizer.sv
